// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MSHSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define MSHSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/mshsd_pkg.sv
// Types and constants of the multi-motor half-step driver.
`timescale 1ns / 1ps
package mshsd_pkg;

  localparam int unsigned REMAIN_W = 23;
  localparam int unsigned SPEED_W  = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MOVE  = 2'd1;
  localparam logic [1:0] FUNC_ANGLE = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  localparam logic [REMAIN_W-1:0] REMAIN_MAX = 23'h7F_FFFF;

  // Coil patterns of the eight half-step phases, bit 0 is the first coil.
  localparam logic [3:0] HALF_STEP_PAT [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  // Division by 45 of a 28-bit value: multiply by ceil(2^34 / 45), shift by 34.
  localparam logic [28:0] DIV45_MUL   = 29'd381774871;
  localparam int unsigned DIV45_SHIFT = 34;

  typedef struct packed {
    logic [2:0]          phase;
    logic [REMAIN_W-1:0] remaining;
    logic                reverse;
    logic [SPEED_W-1:0]  countdown;
    logic [SPEED_W-1:0]  reload;
    logic                energized;
  } mshsd_entry_t;

  typedef struct packed {
    logic [1:0]         func;
    logic               neg;
    logic [23:0]        mag;
    logic [SPEED_W-1:0] speed;
  } mshsd_cmd_t;

endpackage

// File: rtl/multi_stepper_halfstep_driver_top.sv
// Top level of the multi-motor half-step driver: command sequencer and motor state memory.
//
//  Channel | Handshake             | Payload
//  in      | in_valid / in_ready   | in_func, in_motor, in_steps, in_angle, in_speed
//  out     | out_valid / out_ready | out_channel, out_coils, out_running, out_last
//  cfg     | cfg_we                | cfg_wdata (steps per revolution)
//
// A tick accepts the command, reads the first motor's entry, then handles one motor at a time,
// set by the single read port of the state memory.
// A move by steps or a stop reads and updates one entry; a move by angle first has two multiply stages.
// Reset is synchronous; per-entry valid bits clear the state memory at once.
// A result that is not taken holds the sequencer in place; a new transaction is accepted
// whenever the sequencer is idle, even while the last result still waits.
`timescale 1ns / 1ps
module multi_stepper_halfstep_driver_top import mshsd_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [1:0]         in_motor,
  input  logic signed [23:0] in_steps,
  input  logic signed [15:0] in_angle,
  input  logic [15:0]        in_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_channel,
  output logic [3:0]         out_coils,
  output logic               out_running,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int ACTIVE = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACTIVE - 1);
  localparam logic [2:0] ACTIVE_C = 3'(ACTIVE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ANG1 = 3'd1;
  localparam logic [2:0] ST_ANG2 = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_MOD  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [1:0]       motor_r, motor_nxt;
  logic             neg_r, neg_nxt;
  logic [23:0]      mag_r, mag_nxt;
  logic [15:0]      speed_r, speed_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [15:0]      spr_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_channel_r, out_channel_nxt;
  logic [3:0]       out_coils_r, out_coils_nxt;
  logic             out_running_r, out_running_nxt;
  logic             out_last_r, out_last_nxt;

  mshsd_entry_t     mem_r [ACTIVE];
  logic [ACTIVE-1:0] vld_r;
  mshsd_entry_t     rd_data_r;
  logic             rd_vld_r;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr, cmd_addr;
  mshsd_entry_t     cur_entry, upd_entry;
  mshsd_cmd_t       cmd;
  logic [3:0]       upd_coils;
  logic             upd_running;
  logic             in_acc, out_free, is_tick, motor_ok;
  logic [23:0]      steps_mag;
  logic [15:0]      angle_mag;
  logic [56:0]      div_prod;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_tick  = (func_r == FUNC_TICK);
  assign motor_ok = ({1'b0, motor_r} < ACTIVE_C);
  assign cmd_addr = motor_ok ? IDX_W'(motor_r) : '0;

  assign steps_mag = in_steps[23] ? 24'(-in_steps) : 24'(in_steps);
  assign angle_mag = in_angle[15] ? 16'(-in_angle) : 16'(in_angle);
  // angle * steps_per_rev / 360 is computed as ((product >> 3) / 45).
  assign div_prod  = 57'(prod_r[30:3]) * 57'(DIV45_MUL);

  assign cur_entry = rd_vld_r ? rd_data_r : '0;
  assign cmd = '{func: func_r, neg: neg_r, mag: mag_r, speed: speed_r};

  mshsd_update u_update (
    .cmd     (cmd),
    .cur     (cur_entry),
    .nxt     (upd_entry),
    .coils   (upd_coils),
    .running (upd_running)
  );

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    motor_nxt       = motor_r;
    neg_nxt         = neg_r;
    mag_nxt         = mag_r;
    speed_nxt       = speed_r;
    idx_nxt         = idx_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_channel_nxt = out_channel_r;
    out_coils_nxt   = out_coils_r;
    out_running_nxt = out_running_r;
    out_last_nxt    = out_last_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    rd_addr         = is_tick ? idx_r : cmd_addr;
    wr_addr         = is_tick ? idx_r : cmd_addr;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_func;
          motor_nxt = in_motor;
          speed_nxt = in_speed;
          idx_nxt   = '0;
          if (in_func == FUNC_ANGLE) begin
            neg_nxt   = in_angle[15];
            mag_nxt   = {8'd0, angle_mag};
            state_nxt = ST_ANG1;
          end else begin
            neg_nxt   = in_steps[23];
            mag_nxt   = steps_mag;
            state_nxt = ST_RD;
          end
        end
      end
      ST_ANG1: begin
        prod_nxt  = 32'(mag_r[15:0]) * 32'(spr_r);
        state_nxt = ST_ANG2;
      end
      ST_ANG2: begin
        mag_nxt   = {1'b0, div_prod[DIV45_SHIFT +: REMAIN_W]};
        state_nxt = ST_RD;
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = is_tick ? 2'(idx_r) : motor_r;
          out_coils_nxt   = (is_tick || motor_ok) ? upd_coils : 4'h0;
          out_running_nxt = (is_tick || motor_ok) && upd_running;
          out_last_nxt    = !is_tick || (idx_r == LAST_IDX);
          wr_en           = is_tick || motor_ok;
          if (is_tick && (idx_r != LAST_IDX)) begin
            // Fetch the next motor while this one is written back.
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
            rd_en   = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      spr_r       <= 16'd4096;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        spr_r <= cfg_wdata;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    motor_r       <= motor_nxt;
    neg_r         <= neg_nxt;
    mag_r         <= mag_nxt;
    speed_r       <= speed_nxt;
    idx_r         <= idx_nxt;
    prod_r        <= prod_nxt;
    out_channel_r <= out_channel_nxt;
    out_coils_r   <= out_coils_nxt;
    out_running_r <= out_running_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Motor state memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= upd_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_coils   = out_coils_r;
  assign out_running = out_running_r;
  assign out_last    = out_last_r;

endmodule

// File: rtl/mshsd_update.sv
// Per-motor state update for a tick, a move or a stop, and the coil drive it yields.
`timescale 1ns / 1ps
module mshsd_update import mshsd_pkg::*; (
  input  mshsd_cmd_t   cmd,
  input  mshsd_entry_t cur,
  output mshsd_entry_t nxt,
  output logic [3:0]   coils,
  output logic         running
);

  logic [SPEED_W-1:0]  cd_dec;
  logic [REMAIN_W-1:0] rem_dec;
  logic [SPEED_W-1:0]  speed_eff;
  logic [REMAIN_W-1:0] mag_sat;

  assign cd_dec    = cur.countdown - 16'd1;
  assign rem_dec   = cur.remaining - 23'd1;
  assign speed_eff = (cmd.speed == '0) ? 16'd1 : cmd.speed;
  assign mag_sat   = (cmd.mag > {1'b0, REMAIN_MAX}) ? REMAIN_MAX : cmd.mag[REMAIN_W-1:0];

  always_comb begin
    nxt = cur;
    case (cmd.func)
      FUNC_TICK: begin
        if (cur.remaining != '0) begin
          nxt.countdown = cd_dec;
          if (cd_dec == '0) begin
            nxt.phase     = cur.reverse ? (cur.phase + 3'd7) : (cur.phase + 3'd1);
            nxt.remaining = rem_dec;
            if (rem_dec == '0) begin
              // Final step taken: release the coils.
              nxt.energized = 1'b0;
              nxt.reverse   = 1'b0;
            end else begin
              nxt.energized = 1'b1;
              nxt.countdown = cur.reload;
            end
          end
        end
      end
      FUNC_MOVE, FUNC_ANGLE: begin
        if (cmd.mag != '0) begin
          nxt.remaining = mag_sat;
          nxt.reverse   = cmd.neg;
          nxt.reload    = speed_eff;
          nxt.countdown = speed_eff;
        end
      end
      FUNC_STOP: begin
        nxt.remaining = '0;
        nxt.reverse   = 1'b0;
        nxt.countdown = '0;
        nxt.energized = 1'b0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign coils   = nxt.energized ? HALF_STEP_PAT[nxt.phase] : 4'h0;
  assign running = (nxt.remaining != '0);

endmodule

// File: rtl/mshsd_checker.sv
// Port-level checks of the half-step driver's result channel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mshsd_checker import mshsd_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_channel,
  input logic [3:0] out_coils,
  input logic       out_running,
  input logic       out_last
);

  localparam int ACTIVE = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
  localparam logic [2:0] ACTIVE_C = 3'(ACTIVE);

  logic chan_beyond;
  logic coils_legal;

  assign chan_beyond = ({1'b0, out_channel} >= ACTIVE_C);
  assign coils_legal = ($countones(out_coils) == 1) || (out_coils == 4'h3) ||
                       (out_coils == 4'h6) || (out_coils == 4'hC) || (out_coils == 4'h9);

  // A stalled result transaction keeps its payload.
  `MSHSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(out_coils) && $stable(out_running) && $stable(out_last))
  // Coils are released whenever a motor has no steps left.
  `MSHSD_ASSERT_IMP(a_idle_released, clk, rst_n, out_valid && !out_running, out_coils == 4'h0)
  // Energised coils always show one of the half-step patterns.
  `MSHSD_ASSERT_IMP(a_coil_pattern, clk, rst_n, out_valid && (out_coils != 4'h0), coils_legal)
  // A channel beyond the active motors is a lone, idle report.
  `MSHSD_ASSERT_IMP(a_beyond_idle, clk, rst_n, out_valid && chan_beyond, out_last && !out_running && (out_coils == 4'h0))

endmodule

bind multi_stepper_halfstep_driver_top mshsd_checker #(.NUM_MOTORS(NUM_MOTORS)) u_mshsd_checker (.*);

// File: tb/tb_multi_stepper_halfstep_driver_top.sv
// Self-checking testbench for the multi-motor half-step stepper driver.
`timescale 1ns / 1ps
module tb_multi_stepper_halfstep_driver_top;
  import mshsd_pkg::*;

  localparam int MOTORS        = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_PER_SET  = 50;
  localparam logic [22:0] LEFT_MAX = 23'h7F_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  motor;
    logic [23:0] steps;
    logic [15:0] angle;
    logic [15:0] speed;
  } motor_cmd_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [3:0] coils;
    logic       running;
    logic       last;
  } coil_report_t;

  typedef struct {
    motor_cmd_t cmd;
    bit         typed;
    logic [3:0] coils;
    logic       running;
  } cmd_row_t;

  typedef enum {RX_FLOW, RX_COIN, RX_CHOKE} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [1:0]         in_motor;
  logic signed [23:0] in_steps;
  logic signed [15:0] in_angle;
  logic [15:0]        in_speed;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_channel;
  logic [3:0]         out_coils;
  logic               out_running;
  logic               out_last;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  multi_stepper_halfstep_driver_top #(.NUM_MOTORS(MOTORS)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_motor    (in_motor),
    .in_steps    (in_steps),
    .in_angle    (in_angle),
    .in_speed    (in_speed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_coils   (out_coils),
    .out_running (out_running),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // Own copy of the eight-phase half-step coil sequence.
  localparam logic [3:0] COIL_SEQ [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  // Motor state as the block should hold it.
  logic [2:0]  mot_phase  [MOTORS];
  logic [22:0] mot_left   [MOTORS];
  logic        mot_rev    [MOTORS];
  logic [15:0] mot_cnt    [MOTORS];
  logic [15:0] mot_reload [MOTORS];
  logic        mot_energ  [MOTORS];
  logic [15:0] rev_steps;

  coil_report_t coil_reports_q [$];
  cmd_row_t     cmd_table [$];
  int           fail_cnt = 0;
  int           burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coil_report_t motor_report(int ch, bit is_last);
    coil_report_t r;
    r.channel = ch[1:0];
    r.coils   = mot_energ[ch] ? COIL_SEQ[mot_phase[ch]] : 4'h0;
    r.running = (mot_left[ch] != '0);
    r.last    = is_last;
    return r;
  endfunction

  function automatic void load_move(int m, bit neg, logic [31:0] mag, logic [15:0] spd);
    if (mag == 0) return;
    if (mag > LEFT_MAX) mag = LEFT_MAX;
    if (spd == 0) spd = 16'd1;
    mot_left[m]   = mag[22:0];
    mot_rev[m]    = neg;
    mot_reload[m] = spd;
    mot_cnt[m]    = spd;
  endfunction

  // Applies one accepted command to the motor state and queues the reports it causes.
  function automatic void predict_coils(motor_cmd_t c, bit typed, logic [3:0] t_coils,
                                        logic t_running);
    coil_report_t r;
    int           m;
    bit           neg;
    logic [31:0]  mag;
    logic [63:0]  wide;
    m = c.motor;
    if (c.func == FUNC_TICK) begin
      for (int i = 0; i < MOTORS; i++) begin
        if (mot_left[i] != '0) begin
          mot_cnt[i] = mot_cnt[i] - 16'd1;
          if (mot_cnt[i] == '0) begin
            mot_phase[i] = mot_rev[i] ? mot_phase[i] - 3'd1 : mot_phase[i] + 3'd1;
            mot_energ[i] = 1'b1;
            mot_left[i]  = mot_left[i] - 23'd1;
            if (mot_left[i] == '0) begin
              mot_energ[i] = 1'b0;
              mot_rev[i]   = 1'b0;
            end else begin
              mot_cnt[i] = mot_reload[i];
            end
          end
        end
        r = motor_report(i, i == MOTORS - 1);
        if (typed) begin
          r.coils   = t_coils;
          r.running = t_running;
        end
        coil_reports_q.push_back(r);
      end
      return;
    end
    if (c.func == FUNC_MOVE) begin
      neg = c.steps[23];
      mag = neg ? ((32'h100_0000 - {8'd0, c.steps}) & 32'hFF_FFFF) : {8'd0, c.steps};
      load_move(m, neg, mag, c.speed);
    end else if (c.func == FUNC_ANGLE) begin
      neg  = c.angle[15];
      mag  = neg ? (32'h1_0000 - {16'd0, c.angle}) : {16'd0, c.angle};
      wide = (64'(mag) * 64'(rev_steps)) / 64'd360;
      load_move(m, neg, wide[31:0], c.speed);
    end else begin
      mot_left[m]  = '0;
      mot_rev[m]   = 1'b0;
      mot_cnt[m]   = '0;
      mot_energ[m] = 1'b0;
    end
    r = motor_report(m, 1'b1);
    if (typed) begin
      r.coils   = t_coils;
      r.running = t_running;
    end
    coil_reports_q.push_back(r);
  endfunction

  function automatic logic [15:0] random_speed();
    if ($urandom_range(0, 4) != 0) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  // Step moves are mostly short and moves mostly fast, so that motors finish and wrap their phase often.
  function automatic motor_cmd_t random_cmd();
    motor_cmd_t c;
    int         pick;
    int         k;
    pick    = $urandom_range(0, 99);
    c.motor = 2'($urandom);
    c.steps = 24'($urandom);
    c.angle = 16'($urandom);
    c.speed = 16'($urandom);
    if (pick < 45) begin
      c.func = FUNC_TICK;
    end else if (pick < 70) begin
      c.func  = FUNC_MOVE;
      k       = $urandom_range(0, 19);
      if (k == 0) c.steps = '0;
      else if (k > 2) c.steps = $urandom_range(0, 1) ? 24'($urandom_range(1, 24))
                                                     : -24'($urandom_range(1, 24));
      c.speed = random_speed();
    end else if (pick < 85) begin
      c.func = FUNC_ANGLE;
      if ($urandom_range(0, 9) < 7)
        c.angle = $urandom_range(0, 1) ? 16'($urandom_range(0, 720))
                                       : -16'($urandom_range(0, 720));
      c.speed = random_speed();
    end else begin
      c.func = FUNC_STOP;
    end
    return c;
  endfunction

  function automatic void add_row(logic [1:0] func, logic [1:0] motor, logic [23:0] steps,
                                  logic [15:0] angle, logic [15:0] speed, bit typed,
                                  logic [3:0] coils, logic running);
    cmd_row_t row;
    row.cmd     = '{func, motor, steps, angle, speed};
    row.typed   = typed;
    row.coils   = coils;
    row.running = running;
    cmd_table.push_back(row);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic drive_cmd(motor_cmd_t c, bit typed, logic [3:0] t_coils, logic t_running);
    in_valid <= 1'b1;
    in_func  <= c.func;
    in_motor <= c.motor;
    in_steps <= c.steps;
    in_angle <= c.angle;
    in_speed <= c.speed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_coils(c, typed, t_coils, t_running);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every queued report has been seen, then lets the block settle.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    while (coil_reports_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rev_steps(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    rev_steps = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rx_mode_t mode;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      repeat ($urandom_range(4, 40)) begin
        @(negedge clk);
        case (mode)
          RX_FLOW: begin
            out_ready <= 1'b1;
          end
          RX_COIN: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    coil_report_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (coil_reports_q.size() == 0) begin
        $error("unexpected transaction: channel %0d coils %0h", out_channel, out_coils);
        fail_cnt++;
      end else begin
        exp_r = coil_reports_q.pop_front();
        if (out_channel !== exp_r.channel) begin
          $error("out_channel mismatch: expected %0d, actual %0d", exp_r.channel, out_channel);
          fail_cnt++;
        end
        if (out_coils !== exp_r.coils) begin
          $error("out_coils mismatch: expected %0h, actual %0h", exp_r.coils, out_coils);
          fail_cnt++;
        end
        if (out_running !== exp_r.running) begin
          $error("out_running mismatch: expected %0b, actual %0b", exp_r.running, out_running);
          fail_cnt++;
        end
        if (out_last !== exp_r.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", exp_r.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic [15:0] rev_settings [7];
    rev_settings = '{16'd4096, 16'd360, 16'd65535, 16'd1, 16'd0, 16'd7200, 16'd23};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FUNC_TICK;
    in_motor  = '0;
    in_steps  = '0;
    in_angle  = '0;
    in_speed  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rev_steps = 16'd4096;
    for (int i = 0; i < MOTORS; i++) begin
      mot_phase[i]  = '0;
      mot_left[i]   = '0;
      mot_rev[i]    = 1'b0;
      mot_cnt[i]    = '0;
      mot_reload[i] = '0;
      mot_energ[i]  = 1'b0;
    end

    // Directed rows: all coils released after reset, zero moves, speed zero, reverse moves,
    // the oversize count, a move that replaces one in progress, angle extremes and stops.
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);
    add_row(FUNC_STOP,  2'd3, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd0, 24'd0,        16'd0,      16'd5,      1, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd1, 24'd3,        16'd0,      16'd0,      1, 4'h0, 1'b1);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd2, 24'hFF_FFFE,  16'd0,      16'd2,      1, 4'h0, 1'b1);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd0, 24'h80_0000,  16'd0,      16'd1,      1, 4'h0, 1'b1);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd0, 24'd5,        16'd0,      16'd1,      0, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_STOP,  2'd0, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);
    add_row(FUNC_MOVE,  2'd3, 24'h7F_FFFF,  16'd0,      16'hFFFF,   1, 4'h0, 1'b1);
    add_row(FUNC_ANGLE, 2'd1, 24'd0,        16'h7FFF,   16'd3,      1, 4'h0, 1'b1);
    add_row(FUNC_ANGLE, 2'd2, 24'd0,        16'h8000,   16'd1,      1, 4'h0, 1'b1);
    add_row(FUNC_ANGLE, 2'd0, 24'd0,        16'd0,      16'd1,      1, 4'h0, 1'b0);
    add_row(FUNC_TICK,  2'd0, 24'd0,        16'd0,      16'd0,      0, 4'h0, 1'b0);
    add_row(FUNC_STOP,  2'd1, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);
    add_row(FUNC_STOP,  2'd2, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);
    add_row(FUNC_STOP,  2'd3, 24'd0,        16'd0,      16'd0,      1, 4'h0, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rev_settings[p]) begin
      hold_for_results();
      write_rev_steps(rev_settings[p]);
      if (p == 0) begin
        foreach (cmd_table[k])
          drive_cmd(cmd_table[k].cmd, cmd_table[k].typed, cmd_table[k].coils,
                    cmd_table[k].running);
      end
      for (int k = 0; k < RAND_PER_SET; k++) begin
        drive_cmd(random_cmd(), 1'b0, 4'h0, 1'b0);
        // A pause in mid-stream with every report drained.
        if (p == 0 && k == RAND_PER_SET / 2) hold_for_results();
      end
    end

    hold_for_results();
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
